/* hdl/poc_pkg.sv */
// Shared constants, mode codes and control structs for the parity or prime check block.
package poc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
    localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
    localparam int SQ_WIDTH    = 2 * DIV_WIDTH;
    localparam int CNT_WIDTH   = $clog2(MAG_WIDTH + 1);
    localparam int MODE_WIDTH  = 2;

    localparam logic [MODE_WIDTH-1:0] MODE_EVEN  = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_ODD   = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_PRIME = 2'd2;

    localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(5);
    localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(16);
    localparam logic [DIV_WIDTH-1:0] THREE         = DIV_WIDTH'(3);
    localparam logic [DIV_WIDTH-1:0] TWO           = DIV_WIDTH'(2);
    localparam logic [DIV_WIDTH-1:0] SIX           = DIV_WIDTH'(6);
    localparam logic [SQ_WIDTH-1:0]  SQ_STEP_CONST = SQ_WIDTH'(36);

    typedef struct packed {
        logic                 start;
        logic [DIV_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } div_rsp_t;

endpackage

/* hdl/poc_ifs.sv */
// Valid/ready channel interfaces for the value input and the verdict output.
interface poc_value_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [poc_pkg::VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface poc_good_if;
    logic valid;
    logic ready;
    logic good;

    modport source (output valid, output good, input ready);
    modport sink (input valid, input good, output ready);
endinterface

/* hdl/poc_rem.sv */
// Shared restoring remainder unit, one dividend bit per cycle.
module poc_rem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  poc_pkg::div_req_t              req,
    input  logic [poc_pkg::MAG_WIDTH-1:0]  dividend,
    output poc_pkg::div_rsp_t              rsp
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [poc_pkg::CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [poc_pkg::MAG_WIDTH-1:0]   shf_reg, shf_next;
    logic [poc_pkg::DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [poc_pkg::DIV_WIDTH-1:0]   dvs_reg, dvs_next;
    logic [poc_pkg::DIV_WIDTH:0]     trial;
    logic [poc_pkg::DIV_WIDTH:0]     diff;

    assign trial = {rem_reg, shf_reg[poc_pkg::MAG_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = poc_pkg::CNT_WIDTH'(poc_pkg::MAG_WIDTH);
            shf_next  = dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            shf_next = {shf_reg[poc_pkg::MAG_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[poc_pkg::DIV_WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[poc_pkg::DIV_WIDTH-1:0];
            end
            cnt_next = cnt_reg - poc_pkg::CNT_WIDTH'(1);
            if (cnt_reg == poc_pkg::CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shf_reg <= shf_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule

/* hdl/parity_or_prime_check.sv */
// Top level: mode register, trial division sequencer and result register.
// Even, odd, unused-mode and trivially decided prime beats go from acceptance to the finish
// state, which loads the result register once it is free. A prime beat runs each remainder on
// the shared unit: 3, then d and d + 2 for d = 5 + 6k, at most 7723 such pairs.
// One beat is processed at a time; a finished result waits in the output register.
// Reset clears the mode to even, the sequencer to idle and the output valid; no clearing pass.
module parity_or_prime_check (
    input  logic                               clk,
    input  logic                               rst_n,
    poc_value_if.sink                          req,
    poc_good_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [poc_pkg::MODE_WIDTH-1:0]     cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV3  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIVA  = 3'd3;
    localparam logic [2:0] ST_DIVB  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]                       state_reg, state_next;
    logic [poc_pkg::MODE_WIDTH-1:0]   mode_reg;
    logic [poc_pkg::MAG_WIDTH-1:0]    mag_reg, mag_next;
    logic [poc_pkg::DIV_WIDTH-1:0]    d_reg, d_next;
    logic [poc_pkg::SQ_WIDTH-1:0]     sq_reg, sq_next;
    logic                             res_reg, res_next;
    logic                             good_reg, good_next;
    logic                             valid_reg, valid_next;
    logic [poc_pkg::DIV_WIDTH-1:0]    d_minus1;
    logic [poc_pkg::SQ_WIDTH-1:0]     sq_step;
    logic                             in_neg;
    logic                             in_odd;
    logic [poc_pkg::MAG_WIDTH-1:0]    in_mag;
    poc_pkg::div_req_t                div_req;
    poc_pkg::div_rsp_t                div_rsp;

    poc_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (mag_next),
        .rsp      (div_rsp)
    );

    assign in_neg   = req.value[poc_pkg::VALUE_WIDTH-1];
    assign in_odd   = req.value[0];
    assign in_mag   = req.value[poc_pkg::MAG_WIDTH-1:0];
    assign d_minus1 = d_reg - poc_pkg::DIV_WIDTH'(1);
    assign sq_step  = (poc_pkg::SQ_WIDTH'(d_minus1) << 3) + (poc_pkg::SQ_WIDTH'(d_minus1) << 2)
                      + poc_pkg::SQ_STEP_CONST;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = valid_reg;
    assign rsp.good  = good_reg;

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        res_next        = res_reg;
        good_next       = good_reg;
        valid_next      = valid_reg;
        div_req.start   = 1'b0;
        div_req.divisor = d_reg;
        if (valid_reg && rsp.ready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mag_next   = in_mag;
                    state_next = ST_FIN;
                    case (mode_reg)
                        poc_pkg::MODE_EVEN:
                        begin
                            res_next = !in_odd;
                        end
                        poc_pkg::MODE_ODD:
                        begin
                            res_next = in_odd && !in_neg;
                        end
                        poc_pkg::MODE_PRIME:
                        begin
                            if (in_neg || !in_odd)
                            begin
                                res_next = (in_mag == poc_pkg::MAG_WIDTH'(2)) && !in_neg;
                            end
                            else if (in_mag[poc_pkg::MAG_WIDTH-1:2] == '0)
                            begin
                                res_next = in_mag[1];
                            end
                            else
                            begin
                                div_req.start   = 1'b1;
                                div_req.divisor = poc_pkg::THREE;
                                state_next      = ST_DIV3;
                            end
                        end
                        default:
                        begin
                            res_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DIV3:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        d_next     = poc_pkg::FIRST_DIVISOR;
                        sq_next    = poc_pkg::FIRST_SQUARE;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg < poc_pkg::SQ_WIDTH'(mag_reg))
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIVA;
                end
                else
                begin
                    res_next   = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_DIVA:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        div_req.start   = 1'b1;
                        div_req.divisor = d_reg + poc_pkg::TWO;
                        state_next      = ST_DIVB;
                    end
                end
            end
            ST_DIVB:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        d_next     = d_reg + poc_pkg::SIX;
                        sq_next    = sq_reg + sq_step;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FIN:
            begin
                if (!valid_reg || rsp.ready)
                begin
                    valid_next = 1'b1;
                    good_next  = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= poc_pkg::MODE_EVEN;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        good_reg <= good_next;
    end

endmodule

/* hdl/poc_checker.sv */
// Port-level checker for the parity or prime check block and its bind statement.
module poc_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_good
);

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready
    ) else $error("Input was ready again straight after accepting a beat.");

    a_rsp_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_good))
    ) else $error("A stalled result beat was dropped or changed.");

    a_result_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready)
    ) else $error("A result appeared while the block was idle.");

endmodule

bind parity_or_prime_check poc_checker u_poc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_good  (rsp.good)
);

/* tb/sv/tb_parity_or_prime_check.sv */
// Self-checking testbench for parity_or_prime_check: directed and random beats in every mode.
module tb_parity_or_prime_check;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [poc_pkg::MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2_000_000;

    typedef struct {
        logic signed [poc_pkg::VALUE_WIDTH-1:0] value;
        logic [poc_pkg::MODE_WIDTH-1:0]         mode;
        logic                                   good;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [poc_pkg::MODE_WIDTH-1:0] cfg_data;

    poc_value_if value_ch ();
    poc_good_if  good_ch ();

    parity_or_prime_check dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (value_ch),
        .rsp      (good_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    verdict_t                       pending_verdicts[$];
    logic [poc_pkg::MODE_WIDTH-1:0] mode_shadow;
    int                             mismatches;
    int                             idle_cycles;
    int                             send_gap_max;
    int                             result_stall_max;
    verdict_t                       oldest;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic prime_by_trial(input logic [poc_pkg::VALUE_WIDTH-1:0] raw);
        longint unsigned n;
        longint unsigned d;
        n = 64'(raw);
        if (n <= 3)
            return n > 1;
        if ((n % 2) == 0 || (n % 3) == 0)
            return 1'b0;
        for (d = 5; (d - 1) * (d - 1) < n; d += 6)
        begin
            if ((n % d) == 0 || (n % (d + 2)) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic verdict_for(input logic [poc_pkg::MODE_WIDTH-1:0] mode,
                                         input logic signed [poc_pkg::VALUE_WIDTH-1:0] v);
        case (mode)
            poc_pkg::MODE_EVEN:  return !v[0];
            poc_pkg::MODE_ODD:   return v[0] && !v[poc_pkg::VALUE_WIDTH-1];
            poc_pkg::MODE_PRIME: return !v[poc_pkg::VALUE_WIDTH-1] && prime_by_trial(v);
            default:             return 1'b0;
        endcase
    endfunction

    // Trial division is slow for large values, so prime mode mostly draws small ones.
    function automatic logic signed [poc_pkg::VALUE_WIDTH-1:0] draw_value(
        input logic [poc_pkg::MODE_WIDTH-1:0] mode);
        if (mode != poc_pkg::MODE_PRIME)
            return $urandom;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom | 32'h8000_0000;
            2, 3:    return $urandom_range(0, 1 << 20);
            default: return $urandom_range(0, 5000);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic send_value(input logic signed [poc_pkg::VALUE_WIDTH-1:0] v);
        int gap;
        verdict_t exp;
        gap = send_gap_max > 0 ? $urandom_range(0, send_gap_max) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            value_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        do
            @(posedge clk);
        while (!value_ch.ready);
        exp.value = v;
        exp.mode  = mode_shadow;
        exp.good  = verdict_for(mode_shadow, v);
        pending_verdicts.push_back(exp);
    endtask

    task automatic finish_phase();
        @(negedge clk);
        value_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic [poc_pkg::MODE_WIDTH-1:0] m);
        finish_phase();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        mode_shadow = m;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_value(draw_value(mode_shadow));
    endtask

    task automatic test_even_mode();
        send_gap_max     = 4;
        result_stall_max = 4;
        write_mode(poc_pkg::MODE_EVEN);
        send_value(0);
        send_value(-1);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_random(12);
    endtask

    task automatic test_odd_mode();
        send_gap_max     = 0;
        result_stall_max = 0;
        write_mode(poc_pkg::MODE_ODD);
        send_value(1);
        send_value(0);
        send_value(-1);
        send_value(-3);
        send_value(32'sh7FFF_FFFF);
        send_random(12);
    endtask

    task automatic test_prime_mode();
        send_gap_max     = 4;
        result_stall_max = 4;
        write_mode(poc_pkg::MODE_PRIME);
        send_value(0);
        send_value(1);
        send_value(2);
        send_value(3);
        send_value(4);
        send_value(9);
        send_value(25);
        send_value(35);
        send_value(49);
        send_value(121);
        send_value(-7);
        send_value(32'sh8000_0000);
        send_value(1022117);
        // The largest positive value is prime and runs the divisor loop to its end.
        send_value(32'sh7FFF_FFFF);
        send_random(24);
    endtask

    task automatic test_unused_mode();
        send_gap_max     = 2;
        result_stall_max = 4;
        write_mode(MODE_UNUSED);
        send_value(7);
        send_value(2);
        send_random(6);
    endtask

    task automatic test_mode_changes();
        repeat (5)
        begin
            send_gap_max     = $urandom_range(0, 4);
            result_stall_max = $urandom_range(0, 4);
            write_mode(poc_pkg::MODE_WIDTH'($urandom_range(0, 3)));
            send_random(5);
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = poc_pkg::MODE_EVEN;
        value_ch.valid   = 1'b0;
        value_ch.value   = '0;
        mode_shadow      = poc_pkg::MODE_EVEN;
        mismatches       = 0;
        send_gap_max     = 0;
        result_stall_max = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_even_mode();
        test_odd_mode();
        test_prime_mode();
        test_unused_mode();
        test_mode_changes();

        finish_phase();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("parity_or_prime_check: match");
        else
            $display("parity_or_prime_check: mismatch");
        $finish;
    end

    // The sink waits a random number of cycles before taking each result beat.
    initial
    begin
        int stall;
        good_ch.ready = 1'b0;
        forever
        begin
            stall = result_stall_max > 0 ? $urandom_range(0, result_stall_max) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                good_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            good_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!good_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && good_ch.valid && good_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("result beat good=%b with nothing pending",
                                          good_ch.good));
            else
            begin
                oldest = pending_verdicts.pop_front();
                if (good_ch.good !== oldest.good)
                    report_mismatch($sformatf("value %0d mode %0d: good=%b, predicted %b",
                                              oldest.value, oldest.mode, good_ch.good,
                                              oldest.good));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((value_ch.valid && value_ch.ready) || (good_ch.valid && good_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("parity_or_prime_check: mismatch");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
